FILE: rtl/aqc_pkg.sv
// Package for the adaptive quality controller: constants, reset values,
// the decision code type and the controller state struct.
// No dependencies; used by aqc_step and adaptive_quality_controller_top.
package aqc_pkg;

	localparam int unsigned TOP_LEVEL      = 7;
	localparam int unsigned COOLDOWN_STEPS = 8;

	// level is 3 bits and the cooldown counter 4 bits, so both saturate
	localparam logic [2:0] TOP_BOUND  = (TOP_LEVEL > 7) ? 3'd7 : 3'(TOP_LEVEL);
	localparam logic [3:0] RELOAD_CNT = (COOLDOWN_STEPS > 15) ? 4'd15 : 4'(COOLDOWN_STEPS);

	localparam int unsigned TIME_W = 24;
	localparam int unsigned LVL_W  = 3;
	localparam int unsigned CNT_W  = 4;
	localparam int unsigned SUM_W  = TIME_W + 4;

	// floor(n/10) == (n * RECIP_10) >> 35 for every n below 2^32
	localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;
	localparam int unsigned RECIP_SH = 35;

	localparam logic [TIME_W-1:0] RST_TARGET = 24'd4267;
	localparam logic [LVL_W-1:0]  RST_START  = 3'd4;
	localparam logic              RST_ACTIVE = (RST_TARGET != '0) &&
		(32'(RST_START) <= TOP_LEVEL);

	// configuration register indexes
	localparam logic CFG_TARGET = 1'b0;
	localparam logic CFG_START  = 1'b1;

	typedef enum logic [1:0] {
		DEC_HOLD  = 2'd0,
		DEC_LOWER = 2'd1,
		DEC_RAISE = 2'd2
	} decision_t;

	typedef struct packed {
		logic [TIME_W-1:0] avg;
		logic [LVL_W-1:0]  level;
		logic [CNT_W-1:0]  hold;
		logic              active;
	} ctrl_state_t;

endpackage

FILE: rtl/aqc_step.sv
// One controller step: running average update, hysteresis test against
// the target and cooldown handling. Pure combinational; uses aqc_pkg.
module aqc_step (
	input  aqc_pkg::ctrl_state_t         cur,
	input  logic [aqc_pkg::TIME_W-1:0]   target,
	input  logic [aqc_pkg::TIME_W-1:0]   sample,
	input  logic                         sample_ok,
	output aqc_pkg::ctrl_state_t         nxt,
	output aqc_pkg::decision_t           dec
);

	logic [aqc_pkg::SUM_W-1:0] sum;
	logic [59:0]               prod;
	logic [aqc_pkg::TIME_W-1:0] avg_new;
	logic [aqc_pkg::SUM_W-1:0] avg10;
	logic [aqc_pkg::SUM_W-1:0] hi;
	logic [aqc_pkg::SUM_W-1:0] lo;
	logic [aqc_pkg::SUM_W-1:0] avg_w;
	logic [aqc_pkg::SUM_W-1:0] tgt_w;

	assign avg_w = aqc_pkg::SUM_W'(cur.avg);
	assign tgt_w = aqc_pkg::SUM_W'(target);

	// 9*avg + sample stays below 10*2^24
	assign sum     = (avg_w << 3) + avg_w + aqc_pkg::SUM_W'(sample);
	assign prod    = 60'(sum) * 60'(aqc_pkg::RECIP_10);
	assign avg_new = prod[aqc_pkg::RECIP_SH +: aqc_pkg::TIME_W];

	assign avg10 = (aqc_pkg::SUM_W'(avg_new) << 3) + (aqc_pkg::SUM_W'(avg_new) << 1);
	assign hi    = (tgt_w << 3) + (tgt_w << 1) + tgt_w;
	assign lo    = (tgt_w << 3) + tgt_w;

	always_comb begin
		nxt = cur;
		dec = aqc_pkg::DEC_HOLD;
		if (cur.active && sample_ok) begin
			nxt.avg = avg_new;
			if (avg10 > hi && cur.hold == '0 && cur.level != '0) begin
				nxt.level = cur.level - 1'b1;
				nxt.hold  = aqc_pkg::RELOAD_CNT;
				dec       = aqc_pkg::DEC_LOWER;
			end else if (avg10 < lo && cur.hold == '0 && cur.level < aqc_pkg::TOP_BOUND) begin
				nxt.level = cur.level + 1'b1;
				nxt.hold  = aqc_pkg::RELOAD_CNT;
				dec       = aqc_pkg::DEC_RAISE;
			end else if (cur.hold != '0) begin
				nxt.hold = cur.hold - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/adaptive_quality_controller_top.sv
// Adaptive quality controller top level: config registers, state, result
// register and handshakes. Uses aqc_pkg and aqc_step.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  config  | cfg_we, cfg_index, cfg_data               | in
//  input   | in_valid, in_ready, frame_time, sample_ok | in
//  result  | out_valid, out_ready, decision, level_now | out
//
// The state update, divide by ten and threshold tests run between the state
// registers and the result register, so one item is accepted every cycle while
// in_ready is high. The result appears in the cycle after accept.
// in_ready is low only while a result waits and out_ready is low.
// Reset loads target 4267, start level 4, cooldown zero, controller active.
module adaptive_quality_controller_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [aqc_pkg::TIME_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [aqc_pkg::TIME_W-1:0] frame_time,
	input  logic                       sample_ok,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [1:0]                 decision,
	output logic [aqc_pkg::LVL_W-1:0]  level_now
);

	logic [aqc_pkg::TIME_W-1:0] target_q;
	logic [aqc_pkg::LVL_W-1:0]  start_q;
	aqc_pkg::ctrl_state_t       state_q;
	aqc_pkg::ctrl_state_t       state_nxt;
	aqc_pkg::decision_t         dec_nxt;
	logic                       out_valid_q;
	logic [1:0]                 decision_q;
	logic [aqc_pkg::LVL_W-1:0]  level_q;
	logic                       accept;

	logic [aqc_pkg::TIME_W-1:0] new_target;
	logic [aqc_pkg::LVL_W-1:0]  new_start;

	aqc_step u_step (
		.cur       (state_q),
		.target    (target_q),
		.sample    (frame_time),
		.sample_ok (sample_ok),
		.nxt       (state_nxt),
		.dec       (dec_nxt)
	);

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// values seen by the reinit after a config write
	assign new_target = (cfg_index == aqc_pkg::CFG_TARGET) ? cfg_data : target_q;
	assign new_start  = (cfg_index == aqc_pkg::CFG_START) ?
		cfg_data[aqc_pkg::LVL_W-1:0] : start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q       <= aqc_pkg::RST_TARGET;
			start_q        <= aqc_pkg::RST_START;
			state_q.avg    <= aqc_pkg::RST_TARGET;
			state_q.level  <= aqc_pkg::RST_START;
			state_q.hold   <= '0;
			state_q.active <= aqc_pkg::RST_ACTIVE;
		end else if (cfg_we) begin
			target_q       <= new_target;
			start_q        <= new_start;
			state_q.avg    <= new_target;
			state_q.level  <= new_start;
			state_q.hold   <= '0;
			state_q.active <= (new_target != '0) &&
				(32'(new_start) <= aqc_pkg::TOP_LEVEL);
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			decision_q <= dec_nxt;
			level_q    <= state_nxt.level;
		end
	end

	assign out_valid = out_valid_q;
	assign decision  = decision_q;
	assign level_now = level_q;

endmodule
